// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pixel compensation checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tpoc_pkg.sv
// ----------------------------------------------------------------------------
// tpoc_pkg
// Types and constants shared by the pixel offset compensation block.
// ----------------------------------------------------------------------------
package tpoc_pkg;

	// Number of register stages from input to output.
	localparam int STAGES = 7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FACTOR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_DELTA = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_DELTA  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KTA_SHIFT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KV_EVEN_EVEN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KV_EVEN_ODD   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_KV_ODD_EVEN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_KV_ODD_ODD    = 3'd7;

	localparam logic [4:0] KTA_SHIFT_UNITY = 5'd8;

	typedef struct packed {
		logic signed [15:0] raw_sample;
		logic signed [15:0] pixel_offset;
		logic signed [15:0] pixel_kta;
		logic               row_odd;
		logic               col_odd;
		logic               last_pixel;
	} in_pixel_t;

	typedef struct packed {
		logic signed [31:0] compensated_value;
		logic               saturated;
		logic               frame_end;
	} out_pixel_t;

	typedef struct packed {
		logic signed [23:0] gain_factor;
		logic signed [17:0] ambient_delta;
		logic signed [15:0] supply_delta;
		logic        [4:0]  kta_shift;
		logic signed [15:0] kv_even_even;
		logic signed [15:0] kv_even_odd;
		logic signed [15:0] kv_odd_even;
		logic signed [15:0] kv_odd_odd;
	} cfg_t;

	// Per-stage load enables from the pipeline control to the datapath.
	typedef struct packed {
		logic [STAGES-1:0] load;
	} stage_ctl_t;

endpackage

// File: rtl/tpoc_cfg.sv
// ----------------------------------------------------------------------------
// tpoc_cfg
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module tpoc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tpoc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpoc_pkg::CFG_DATA_W-1:0] cfg_data,
	output tpoc_pkg::cfg_t                  cfg
);
	import tpoc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_factor   <= 24'sd65536;
			cfg_q.ambient_delta <= '0;
			cfg_q.supply_delta  <= '0;
			cfg_q.kta_shift     <= KTA_SHIFT_UNITY;
			cfg_q.kv_even_even  <= '0;
			cfg_q.kv_even_odd   <= '0;
			cfg_q.kv_odd_even   <= '0;
			cfg_q.kv_odd_odd    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GAIN_FACTOR:   cfg_q.gain_factor   <= cfg_data;
				CFG_AMBIENT_DELTA: cfg_q.ambient_delta <= cfg_data[17:0];
				CFG_SUPPLY_DELTA:  cfg_q.supply_delta  <= cfg_data[15:0];
				CFG_KTA_SHIFT:     cfg_q.kta_shift     <= cfg_data[4:0];
				CFG_KV_EVEN_EVEN:  cfg_q.kv_even_even  <= cfg_data[15:0];
				CFG_KV_EVEN_ODD:   cfg_q.kv_even_odd   <= cfg_data[15:0];
				CFG_KV_ODD_EVEN:   cfg_q.kv_odd_even   <= cfg_data[15:0];
				CFG_KV_ODD_ODD:    cfg_q.kv_odd_odd    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/tpoc_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// tpoc_pipe_ctrl
// Valid bits and per-stage load enables; bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module tpoc_pipe_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output tpoc_pkg::stage_ctl_t   ctl
);
	import tpoc_pkg::*;

	logic [STAGES-1:0] valid_q;
	logic [STAGES-1:0] load;

	// A stage takes new contents when it is empty or its contents move on.
	always_comb begin
		load[STAGES-1] = !valid_q[STAGES-1] || out_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			load[k] = !valid_q[k] || load[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (load[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign in_ready  = load[0];
	assign out_valid = valid_q[STAGES-1];
	assign ctl.load  = load;

endmodule

// File: rtl/tpoc_datapath.sv
// ----------------------------------------------------------------------------
// tpoc_datapath
// Seven-stage fixed-point datapath: gain, ambient and supply factors, then
// the offset product split into partial products, rounding and saturation.
// ----------------------------------------------------------------------------
module tpoc_datapath (
	input  logic                  clk,
	input  tpoc_pkg::cfg_t        cfg,
	input  tpoc_pkg::stage_ctl_t  ctl,
	input  tpoc_pkg::in_pixel_t   in_data,
	output tpoc_pkg::out_pixel_t  out_data
);
	import tpoc_pkg::*;

	// Stage 1: the three small products.
	logic signed [39:0] g_prod_s1;
	logic signed [33:0] ta_prod_s1;
	logic signed [31:0] kv_prod_s1;
	logic signed [15:0] off_s1;
	logic               last_s1;
	logic signed [15:0] kv_sel;

	always_comb begin
		case ({in_data.row_odd, in_data.col_odd})
			2'b00:   kv_sel = cfg.kv_even_even;
			2'b01:   kv_sel = cfg.kv_even_odd;
			2'b10:   kv_sel = cfg.kv_odd_even;
			2'b11:   kv_sel = cfg.kv_odd_odd;
			default: kv_sel = cfg.kv_even_even;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			g_prod_s1  <= in_data.raw_sample * cfg.gain_factor;
			ta_prod_s1 <= in_data.pixel_kta * cfg.ambient_delta;
			kv_prod_s1 <= kv_sel * cfg.supply_delta;
			off_s1     <= in_data.pixel_offset;
			last_s1    <= in_data.last_pixel;
		end
	end

	// Stage 2: rounding of the gain term, ambient factor A and supply factor B.
	logic signed [31:0] g_s2;
	logic signed [42:0] fa_s2;
	logic signed [18:0] fb_s2;
	logic signed [15:0] off_s2;
	logic               last_s2;

	logic signed [39:0] g_rnd;
	logic signed [32:0] kv_rnd;
	logic signed [34:0] ta_rnd;
	logic signed [42:0] ta_term;
	logic        [4:0]  rsh;

	always_comb begin
		g_rnd  = g_prod_s1 + 40'sd128;
		kv_rnd = 33'(kv_prod_s1) + 33'sd8192;
		rsh    = cfg.kta_shift - KTA_SHIFT_UNITY;
		ta_rnd = (35'(ta_prod_s1) + (35'sd1 <<< (rsh - 5'd1))) >>> rsh;
		// A shift of eight or less scales the product up instead of rounding.
		if (cfg.kta_shift <= KTA_SHIFT_UNITY) begin
			ta_term = 43'(ta_prod_s1) <<< (KTA_SHIFT_UNITY - cfg.kta_shift);
		end else begin
			ta_term = 43'(ta_rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			g_s2    <= g_rnd[39:8];
			fa_s2   <= 43'sd65536 + ta_term;
			fb_s2   <= 19'sd16384 + 19'(kv_rnd[32:14]);
			off_s2  <= off_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: offset times A as two partial products.
	logic signed [38:0] pa_lo_s3;
	logic signed [36:0] pa_hi_s3;
	logic signed [31:0] g_s3;
	logic signed [18:0] fb_s3;
	logic               last_s3;

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			pa_lo_s3 <= off_s2 * $signed({1'b0, fa_s2[21:0]});
			pa_hi_s3 <= off_s2 * $signed(fa_s2[42:22]);
			g_s3     <= g_s2;
			fb_s3    <= fb_s2;
			last_s3  <= last_s2;
		end
	end

	// Stage 4: recombine, round to Q.8 and clamp P.
	localparam logic signed [50:0] P_LIM = 51'sd70368744177664;

	logic signed [47:0] p_s4;
	logic signed [31:0] g_s4;
	logic signed [18:0] fb_s4;
	logic               last_s4;

	logic signed [58:0] pa_sum;
	logic signed [50:0] p_rnd;

	always_comb begin
		pa_sum = (59'(pa_hi_s3) <<< 22) + 59'(pa_lo_s3) + 59'sd128;
		p_rnd  = pa_sum[58:8];
	end

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			if (p_rnd > P_LIM) begin
				p_s4 <= 48'(P_LIM);
			end else if (p_rnd < -P_LIM) begin
				p_s4 <= 48'(-P_LIM);
			end else begin
				p_s4 <= p_rnd[47:0];
			end
			g_s4    <= g_s3;
			fb_s4   <= fb_s3;
			last_s4 <= last_s3;
		end
	end

	// Stage 5: P times B as two partial products.
	logic signed [43:0] pb_lo_s5;
	logic signed [42:0] pb_hi_s5;
	logic signed [31:0] g_s5;
	logic               last_s5;

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			pb_lo_s5 <= $signed({1'b0, p_s4[23:0]}) * fb_s4;
			pb_hi_s5 <= $signed(p_s4[47:24]) * fb_s4;
			g_s5     <= g_s4;
			last_s5  <= last_s4;
		end
	end

	// Stage 6: recombine and round C to Q.8.
	logic signed [51:0] c_s6;
	logic signed [31:0] g_s6;
	logic               last_s6;

	logic signed [65:0] pb_sum;

	always_comb begin
		pb_sum = (66'(pb_hi_s5) <<< 24) + 66'(pb_lo_s5) + 66'sd8192;
	end

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			c_s6    <= pb_sum[65:14];
			g_s6    <= g_s5;
			last_s6 <= last_s5;
		end
	end

	// Stage 7: difference and saturation to 32 bits; this is the output register.
	localparam logic signed [52:0] R_MAX = 53'sd2147483647;
	localparam logic signed [52:0] R_MIN = -53'sd2147483648;

	out_pixel_t out_s7;
	logic signed [52:0] r_diff;

	assign r_diff = 53'(g_s6) - 53'(c_s6);

	always_ff @(posedge clk) begin
		if (ctl.load[6]) begin
			if (r_diff > R_MAX) begin
				out_s7.compensated_value <= 32'(R_MAX);
				out_s7.saturated         <= 1'b1;
			end else if (r_diff < R_MIN) begin
				out_s7.compensated_value <= 32'(R_MIN);
				out_s7.saturated         <= 1'b1;
			end else begin
				out_s7.compensated_value <= r_diff[31:0];
				out_s7.saturated         <= 1'b0;
			end
			out_s7.frame_end <= last_s6;
		end
	end

	assign out_data = out_s7;

endmodule

// File: rtl/thermal_pixel_offset_compensate_top.sv
// ----------------------------------------------------------------------------
// thermal_pixel_offset_compensate_top
// Per-pixel offset, ambient and supply compensation for a thermopile array.
// ----------------------------------------------------------------------------
// Channel   Signals                                Role
// pixel in  in_valid, in_ready, in_data            raw sample, offset, kta, parity
// result    out_valid, out_ready, out_data         compensated Q24.8 value, flags
// config    cfg_we, cfg_index, cfg_data            register writes, no read-back
//
// One pixel is accepted per cycle while in_ready is high; each pixel passes
// through the seven register stages of the multiply chain before out_valid
// rises for its result.
// Reset empties the pipeline and loads the register defaults.
// Under an output stall the pipeline fills its empty stages before in_ready
// drops, and resumes without losing or repeating a pixel.
// ----------------------------------------------------------------------------
module thermal_pixel_offset_compensate_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  tpoc_pkg::in_pixel_t             in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output tpoc_pkg::out_pixel_t            out_data,
	input  logic                            cfg_we,
	input  logic [tpoc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpoc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tpoc_pkg::*;

	cfg_t       cfg;
	stage_ctl_t ctl;

	tpoc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tpoc_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	tpoc_datapath u_dp (
		.clk      (clk),
		.cfg      (cfg),
		.ctl      (ctl),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

// File: rtl/tpoc_checker.sv
// ----------------------------------------------------------------------------
// tpoc_checker
// Port-level checks for the pixel compensation block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpoc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input tpoc_pkg::in_pixel_t  in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input tpoc_pkg::out_pixel_t out_data
);
	import tpoc_pkg::*;

	// A held result must not change until its transfer.
	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

	// A clipped result sits exactly on one of the two limits.
	`ASSERT_CLK(a_sat_limit, out_valid && out_data.saturated |-> out_data.compensated_value == 32'sh7fffffff || out_data.compensated_value == 32'sh80000000, "saturated flag without limit value")

	// With the sink ready the pipeline never holds off a pixel.
	`ASSERT_ALWAYS(a_ready_flow, out_ready |-> in_ready, "input stalled while output was ready")

	// Nothing is presented while reset is held.
	`ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind thermal_pixel_offset_compensate_top tpoc_checker u_chk (.*);
